// ----- design/tsli_pkg.sv -----
// Shared types, constants and codes for the time series linear interpolator.
package tsli_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int FRAC_BITS  = 16;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int DATA_W     = 32;
    localparam int STEP_W     = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int MF_CNT_W   = $clog2(DATA_W);

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OUTSIDE  = 2'd1,
        ST_ZERO_LEN = 2'd2,
        ST_LOAD_ACK = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_T1, S_T2, S_FWD, S_BWD, S_INT, S_DIV, S_UCHK,
        S_RDV, S_V1, S_V2, S_MF, S_ADD, S_EQ, S_MUL_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_QUERY, OP_CHECK, OP_T1, OP_T2, OP_FWD_STEP, OP_FWD_END,
        OP_BWD_START, OP_BWD_STEP, OP_BWD_END, OP_EXP_SET, OP_DIV_START, OP_MF_STEP,
        OP_UNI_SET, OP_RDV, OP_V1, OP_MF_START, OP_ADD, OP_EQ, OP_MUL, OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        logic    set_code;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        logic q_neg;
        logic n_zero;
        logic uniform;
        logic q_eq_rd;
        logic q_gt_rd;
        logic q_lt_rd;
        logic q_lt_t1;
        logic c_last;
        logic c_zero;
        logic c2_lt_n;
        logic t2_le_t1;
        logic mf_last;
        logic u_oor;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- design/tsli_ctrl.sv -----
// Controller state machine: sequences loads, cursor walk, divide and scaling.
module tsli_ctrl import tsli_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_mode,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.op       = OP_NONE;
        o_cmd.set_code = 1'b0;
        o_cmd.code     = ST_OK;
        o_in_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!i_mode) begin
                        o_cmd.op       = OP_LOAD;
                        o_cmd.set_code = 1'b1;
                        o_cmd.code     = ST_LOAD_ACK;
                        n_state        = S_MUL_OUT;
                    end else begin
                        o_cmd.op = OP_QUERY;
                        n_state  = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.q_neg || i_sts.n_zero) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_OUTSIDE;
                    n_state        = S_MUL_OUT;
                end else if (i_sts.uniform) begin
                    o_cmd.op = OP_DIV_START;
                    n_state  = S_DIV;
                end else begin
                    o_cmd.op = OP_CHECK;
                    n_state  = S_T1;
                end
            end
            S_T1: begin
                if (i_sts.q_eq_rd) begin
                    o_cmd.op = OP_T1;
                    n_state  = S_EQ;
                end else if ((i_sts.q_gt_rd && i_sts.c_last) ||
                             (i_sts.q_lt_rd && i_sts.c_zero)) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_OUTSIDE;
                    n_state        = S_MUL_OUT;
                end else begin
                    o_cmd.op = OP_T1;
                    n_state  = S_T2;
                end
            end
            S_T2, S_FWD: begin
                if (i_sts.q_gt_rd && i_sts.c2_lt_n) begin
                    o_cmd.op = OP_FWD_STEP;
                    n_state  = S_FWD;
                end else if (i_sts.q_gt_rd) begin
                    o_cmd.op       = OP_FWD_END;
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_OUTSIDE;
                    n_state        = S_MUL_OUT;
                end else if (r_state == S_FWD) begin
                    o_cmd.op = OP_FWD_END;
                    n_state  = S_INT;
                end else if (i_sts.q_lt_t1) begin
                    o_cmd.op = OP_BWD_START;
                    n_state  = S_BWD;
                end else begin
                    o_cmd.op = OP_T2;
                    n_state  = S_INT;
                end
            end
            S_BWD: begin
                if (i_sts.q_lt_rd && !i_sts.c_zero) begin
                    o_cmd.op = OP_BWD_STEP;
                end else if (i_sts.q_lt_rd) begin
                    o_cmd.op       = OP_BWD_END;
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_OUTSIDE;
                    n_state        = S_MUL_OUT;
                end else begin
                    o_cmd.op = OP_BWD_END;
                    n_state  = S_INT;
                end
            end
            S_INT: begin
                if (i_sts.t2_le_t1) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_ZERO_LEN;
                    n_state        = S_MUL_OUT;
                end else begin
                    o_cmd.op = OP_EXP_SET;
                    n_state  = S_RDV;
                end
            end
            S_DIV: begin
                o_cmd.op = OP_MF_STEP;
                if (i_sts.mf_last) begin
                    n_state = S_UCHK;
                end
            end
            S_UCHK: begin
                if (i_sts.u_oor) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_OUTSIDE;
                    n_state        = S_MUL_OUT;
                end else begin
                    o_cmd.op = OP_UNI_SET;
                    n_state  = S_RDV;
                end
            end
            S_RDV: begin
                o_cmd.op = OP_RDV;
                n_state  = S_V1;
            end
            S_V1: begin
                o_cmd.op = OP_V1;
                n_state  = S_V2;
            end
            S_V2: begin
                o_cmd.op = OP_MF_START;
                n_state  = S_MF;
            end
            S_MF: begin
                o_cmd.op = OP_MF_STEP;
                if (i_sts.mf_last) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.op = OP_ADD;
                n_state  = S_EQ;
            end
            S_EQ: begin
                // interp already in place when coming from S_ADD
                o_cmd.op       = OP_MUL;
                o_cmd.set_code = 1'b1;
                o_cmd.code     = ST_OK;
                n_state        = S_MUL_OUT;
            end
            S_MUL_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/tsli_dp.sv -----
// Datapath: point stores, cursor, shared serial multiply-divide, scaling, result register.
module tsli_dp import tsli_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic                 i_from_eq,
    input  logic [ADDR_W-1:0]    i_point_index,
    input  logic signed [DATA_W-1:0] i_point_time,
    input  logic signed [DATA_W-1:0] i_point_value,
    input  logic signed [DATA_W-1:0] i_query_time,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic signed [DATA_W-1:0] o_result_value,
    output logic [1:0]           o_status,
    output logic                 o_saturated
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);
    localparam logic signed [2*DATA_W-1:0] SAT_MAX = (2*DATA_W)'(64'sh7FFF_FFFF);
    localparam logic signed [2*DATA_W-1:0] SAT_MIN = -SAT_MAX - (2*DATA_W)'(1);

    logic signed [DATA_W-1:0] r_time_mem  [MAX_POINTS];
    logic signed [DATA_W-1:0] r_value_mem [MAX_POINTS];
    logic signed [DATA_W-1:0] r_rd_t, r_rd_v;

    logic signed [DATA_W-1:0] r_scale;
    logic [STEP_W-1:0]        r_step;
    logic [CNT_W-1:0]         r_count;
    logic [ADDR_W-1:0]        r_cursor;
    logic                     r_out_valid;

    logic signed [DATA_W-1:0] r_q, r_t1, r_t2, r_v1, r_interp;
    logic [ADDR_W-1:0]        r_idx;
    logic [DATA_W-1:0]        r_num, r_den, r_mf_a, r_mf_b, r_mf_c, r_rem, r_quo;
    logic [MF_CNT_W-1:0]      r_mf_cnt;
    logic                     r_neg;
    logic signed [2*DATA_W-1:0] r_prod;
    t_status                  r_code;
    logic signed [DATA_W-1:0] r_out_value;
    t_status                  r_out_status;
    logic                     r_out_sat;

    logic [CNT_W-1:0]         n_eff;
    logic [ADDR_W-1:0]        c_fix, t_addr, v_addr;
    logic [DATA_W+1:0]        mf_t, mf_c1, mf_c2, mf_t_sub;
    logic [1:0]               mf_d;
    logic [DATA_W-1:0]        n_rem, n_quo;
    logic signed [DATA_W:0]   dv;
    logic [DATA_W:0]          dv_mag;
    logic signed [DATA_W:0]   interp_sum;
    logic signed [2*DATA_W-1:0] prod_sh;
    logic signed [DATA_W-1:0] sat_val;
    logic                     sat_flag;

    assign n_eff = (r_count > MAX_CNT) ? MAX_CNT : r_count;
    assign c_fix = ({1'b0, r_cursor} >= n_eff) ? '0 : r_cursor;

    // Read addresses follow the operation that wants the data next cycle
    always_comb begin
        case (i_cmd.op)
            OP_CHECK:                 t_addr = c_fix;
            OP_T1:                    t_addr = r_idx + ADDR_W'(1);
            OP_FWD_STEP:              t_addr = r_idx + ADDR_W'(2);
            OP_BWD_START, OP_BWD_STEP: t_addr = r_idx - ADDR_W'(1);
            default:                  t_addr = r_idx;
        endcase
        v_addr = (i_cmd.op == OP_V1) ? r_idx + ADDR_W'(1) : r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_time_mem[i_point_index]  <= i_point_time;
            r_value_mem[i_point_index] <= i_point_value;
        end
        r_rd_t <= r_time_mem[t_addr];
        r_rd_v <= r_value_mem[v_addr];
    end

    // One step of floor(a*b/c): partial remainder stays below c, so digit is 0..2
    always_comb begin
        mf_t  = {1'b0, r_rem, 1'b0} + {2'b0, (r_mf_a[DATA_W-1] ? r_mf_b : '0)};
        mf_c1 = {2'b0, r_mf_c};
        mf_c2 = {1'b0, r_mf_c, 1'b0};
        if (mf_t >= mf_c2) begin
            mf_d     = 2'd2;
            mf_t_sub = mf_t - mf_c2;
        end else if (mf_t >= mf_c1) begin
            mf_d     = 2'd1;
            mf_t_sub = mf_t - mf_c1;
        end else begin
            mf_d     = 2'd0;
            mf_t_sub = mf_t;
        end
        n_rem = mf_t_sub[DATA_W-1:0];
        n_quo = {r_quo[DATA_W-2:0], 1'b0} + DATA_W'(mf_d);
    end

    assign dv         = {r_rd_v[DATA_W-1], r_rd_v} - {r_v1[DATA_W-1], r_v1};
    assign dv_mag     = dv[DATA_W] ? -dv : dv;
    assign interp_sum = r_neg ? ({r_v1[DATA_W-1], r_v1} - {1'b0, r_quo})
                              : ({r_v1[DATA_W-1], r_v1} + {1'b0, r_quo});

    assign prod_sh = r_prod >>> FRAC_BITS;
    always_comb begin
        if (prod_sh > SAT_MAX) begin
            sat_val  = SAT_MAX[DATA_W-1:0];
            sat_flag = 1'b1;
        end else if (prod_sh < SAT_MIN) begin
            sat_val  = SAT_MIN[DATA_W-1:0];
            sat_flag = 1'b1;
        end else begin
            sat_val  = prod_sh[DATA_W-1:0];
            sat_flag = 1'b0;
        end
    end

    // Control state: configuration, cursor, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= DATA_W'(32'sd65536);
            r_step      <= '0;
            r_count     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SCALE: r_scale <= i_cfg_data;
                    CFG_STEP:  r_step  <= i_cfg_data[STEP_W-1:0];
                    CFG_COUNT: r_count <= i_cfg_data[CNT_W-1:0];
                    default:   ;
                endcase
            end
            case (i_cmd.op)
                OP_LOAD:                r_cursor <= '0;
                OP_CHECK:               r_cursor <= c_fix;
                OP_FWD_END, OP_BWD_END: r_cursor <= r_idx;
                default:                ;
            endcase
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_code) begin
            r_code <= i_cmd.code;
        end
        case (i_cmd.op)
            OP_QUERY:     r_q <= i_query_time;
            OP_CHECK:     r_idx <= c_fix;
            OP_T1:        r_t1 <= r_rd_t;
            OP_T2:        r_t2 <= r_rd_t;
            OP_FWD_STEP: begin
                r_idx <= r_idx + ADDR_W'(1);
                r_t1  <= r_rd_t;
            end
            OP_FWD_END:   r_t2 <= r_rd_t;
            OP_BWD_START: begin
                r_idx <= r_idx - ADDR_W'(1);
                r_t2  <= r_t1;
            end
            OP_BWD_STEP: begin
                r_idx <= r_idx - ADDR_W'(1);
                r_t2  <= r_rd_t;
            end
            OP_BWD_END:   r_t1 <= r_rd_t;
            OP_EXP_SET: begin
                r_num <= DATA_W'(r_q - r_t1);
                r_den <= DATA_W'(r_t2 - r_t1);
            end
            OP_DIV_START: begin
                r_mf_a   <= r_q;
                r_mf_b   <= DATA_W'(1);
                r_mf_c   <= {1'b0, r_step};
                r_rem    <= '0;
                r_quo    <= '0;
                r_mf_cnt <= '0;
            end
            OP_MF_STEP: begin
                r_mf_a   <= {r_mf_a[DATA_W-2:0], 1'b0};
                r_rem    <= n_rem;
                r_quo    <= n_quo;
                r_mf_cnt <= r_mf_cnt + MF_CNT_W'(1);
            end
            OP_UNI_SET: begin
                r_idx <= r_quo[ADDR_W-1:0];
                r_num <= r_rem;
                r_den <= {1'b0, r_step};
            end
            OP_V1:        r_v1 <= r_rd_v;
            OP_MF_START: begin
                r_neg    <= dv[DATA_W];
                r_mf_a   <= dv_mag[DATA_W-1:0];
                r_mf_b   <= r_num;
                r_mf_c   <= r_den;
                r_rem    <= '0;
                r_quo    <= '0;
                r_mf_cnt <= '0;
            end
            OP_ADD:       r_interp <= interp_sum[DATA_W-1:0];
            OP_MUL:       r_prod <= (i_from_eq ? r_rd_v : r_interp) * r_scale;
            OP_EMIT: begin
                r_out_value  <= (r_code == ST_OK) ? sat_val : '0;
                r_out_status <= r_code;
                r_out_sat    <= (r_code == ST_OK) ? sat_flag : 1'b0;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.q_neg    = r_q[DATA_W-1];
        o_sts.n_zero   = (n_eff == '0);
        o_sts.uniform  = (r_step != '0);
        o_sts.q_eq_rd  = (r_q == r_rd_t);
        o_sts.q_gt_rd  = (r_q > r_rd_t);
        o_sts.q_lt_rd  = (r_q < r_rd_t);
        o_sts.q_lt_t1  = (r_q < r_t1);
        o_sts.c_last   = ({1'b0, r_idx} == n_eff - CNT_W'(1));
        o_sts.c_zero   = (r_idx == '0);
        o_sts.c2_lt_n  = (({1'b0, r_idx} + CNT_W'(2)) < n_eff);
        o_sts.t2_le_t1 = (r_t2 <= r_t1);
        o_sts.mf_last  = (r_mf_cnt == {MF_CNT_W{1'b1}});
        o_sts.u_oor    = (({1'b0, r_quo} + (DATA_W+1)'(1)) >= (DATA_W+1)'(n_eff));
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_saturated    = r_out_sat;

endmodule

// ----- design/time_series_linear_interpolator_top.sv -----
// Top level of the time series linear interpolator: controller plus datapath.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | to block  | i_in_valid / o_in_ready   | i_mode, i_point_index, i_point_time,
//          |           |                           | i_point_value, i_query_time
//  out     | from block| o_out_valid / i_out_ready | o_result_value, o_status, o_saturated
//  cfg     | to block  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One transaction at a time.
// An explicit-time query walks the cursor one point at a time; a uniform query instead runs
// the 32-step serial divide by the step in place of the cursor set-up. Both paths share
// the one-digit multiply-divide unit (32 steps per use) and one read per cycle from each
// point store.
// Reset is synchronous, active low: it restores the configuration defaults,
// clears the cursor and drops any pending result; the point stores keep their data.
// A stalled output holds the result; the next input transaction is taken while it waits.
module time_series_linear_interpolator_top import tsli_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_mode,
    input  logic [ADDR_W-1:0]        i_point_index,
    input  logic signed [DATA_W-1:0] i_point_time,
    input  logic signed [DATA_W-1:0] i_point_value,
    input  logic signed [DATA_W-1:0] i_query_time,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_result_value,
    output logic [1:0]               o_status,
    output logic                     o_saturated,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    r_from_eq;

    // Configuration is always taken; the user must send it only while the block is quiet (not enforced here)
    assign o_cfg_ready = 1'b1;

    // Remember whether the exact-hit path fed the scaler (value comes from store read)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_from_eq <= 1'b0;
        end else if (cmd.op == OP_T1) begin
            r_from_eq <= sts.q_eq_rd;
        end else if (cmd.op == OP_ADD) begin
            r_from_eq <= 1'b0;
        end
    end

    tsli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tsli_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_from_eq      (r_from_eq),
        .i_point_index  (i_point_index),
        .i_point_time   (i_point_time),
        .i_point_value  (i_point_value),
        .i_query_time   (i_query_time),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_saturated    (o_saturated)
    );

endmodule

// ----- design/tsli_checker.sv -----
// Port-level checker for the interpolator, bound to the top level.
module tsli_sva import tsli_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic signed [DATA_W-1:0] o_result_value,
    input logic [1:0]               o_status,
    input logic                     o_saturated
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_value)
            && $stable(o_status))
        else $error("result dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transaction taken while one is in flight");

    a_sat_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |-> o_status == ST_OK)
        else $error("saturation flagged on a non-ok result");

    a_zero_when_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_result_value == '0)
        else $error("non-zero value on a non-ok result");

endmodule

bind time_series_linear_interpolator_top tsli_sva u_tsli_sva (.*);

// ----- tb/sv/tsli_checker.sv -----
// Checker for the interpolator: watches all three channels, predicts each result and compares.
module tsli_checker import tsli_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic                     i_mode,
    input  logic [ADDR_W-1:0]        i_point_index,
    input  logic signed [DATA_W-1:0] i_point_time,
    input  logic signed [DATA_W-1:0] i_point_value,
    input  logic signed [DATA_W-1:0] i_query_time,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic signed [DATA_W-1:0] i_result_value,
    input  logic [1:0]               i_status,
    input  logic                     i_saturated,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data,
    output int                       o_err_count,
    output int                       o_pending,
    output int                       o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        t_status                  status;
        logic                     sat;
    } t_answer;

    t_answer                  answers_q[$];
    logic signed [DATA_W-1:0] time_mem  [MAX_POINTS];
    logic signed [DATA_W-1:0] value_mem [MAX_POINTS];
    int                       walk_pos;
    logic signed [DATA_W-1:0] gain;
    logic [STEP_W-1:0]        step;
    logic [CNT_W-1:0]         count;

    function automatic t_answer plain(t_status st);
        t_answer a;
        a.value  = '0;
        a.status = st;
        a.sat    = 1'b0;
        return a;
    endfunction

    // Apply the gain with a floor shift, then clip to 32 bits.
    function automatic t_answer apply_gain(longint v);
        logic signed [127:0] p;
        logic signed [127:0] r;
        t_answer             a;
        p = gain;
        p = p * v;
        r = p >>> FRAC_BITS;
        a = plain(ST_OK);
        if (r > 128'sd2147483647) begin
            a.value = 32'h7FFF_FFFF;
            a.sat   = 1'b1;
        end else if (r < -128'sd2147483648) begin
            a.value = 32'h8000_0000;
            a.sat   = 1'b1;
        end else begin
            a.value = r[31:0];
        end
        return a;
    endfunction

    // v1 plus the truncated fraction num/den of the rise to v2.
    function automatic longint blend(longint v1, longint v2, longint unsigned num,
                                     longint unsigned den);
        longint          dv;
        longint unsigned mag;
        logic [127:0]    prod;
        longint          off;
        if (den == 0) return v1;
        if (num > den) num = den;
        dv   = v2 - v1;
        mag  = (dv < 0) ? -dv : dv;
        prod = mag;
        prod = prod * num;
        off  = longint'(prod / den);
        return (dv < 0) ? v1 - off : v1 + off;
    endfunction

    function automatic t_answer lookup(logic m, logic [ADDR_W-1:0] idx,
                                       logic signed [DATA_W-1:0] pt,
                                       logic signed [DATA_W-1:0] pv,
                                       logic signed [DATA_W-1:0] qt);
        longint          n;
        longint          q;
        longint          t1;
        longint          t2;
        longint unsigned seg;
        longint unsigned rem;
        int              c;
        if (!m) begin
            time_mem[idx]  = pt;
            value_mem[idx] = pv;
            walk_pos       = 0;
            return plain(ST_LOAD_ACK);
        end
        n = (count > MAX_POINTS) ? MAX_POINTS : count;
        q = qt;
        if (q < 0 || n == 0) return plain(ST_OUTSIDE);
        if (step != 0) begin
            seg = longint'(q) / step;
            rem = longint'(q) - seg * step;
            if (seg + 1 >= n) return plain(ST_OUTSIDE);
            return apply_gain(blend(value_mem[seg], value_mem[seg+1], rem, step));
        end
        if (walk_pos >= n) walk_pos = 0;
        c  = walk_pos;
        t1 = time_mem[c];
        if (q == t1) return apply_gain(value_mem[c]);
        if ((q > t1 && c == n - 1) || (q < t1 && c == 0)) return plain(ST_OUTSIDE);
        t2 = time_mem[c+1];
        if (q > t2) begin
            while (q > t2 && c + 2 < n) begin
                c++;
                t1 = t2;
                t2 = time_mem[c+1];
            end
            walk_pos = c;
            if (q > t2) return plain(ST_OUTSIDE);
        end else if (q < t1) begin
            while (q < t1 && c > 0) begin
                c--;
                t2 = t1;
                t1 = time_mem[c];
            end
            walk_pos = c;
            if (q < t1) return plain(ST_OUTSIDE);
        end
        if (t2 <= t1) return plain(ST_ZERO_LEN);
        return apply_gain(blend(value_mem[c], value_mem[c+1], q - t1, t2 - t1));
    endfunction

    initial begin
        o_err_count = 0;
        o_pending   = 0;
        o_checked   = 0;
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            walk_pos = 0;
            gain     = 32'sd65536;
            step     = '0;
            count    = '0;
            answers_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SCALE: gain  = i_cfg_data;
                    CFG_STEP:  step  = i_cfg_data[STEP_W-1:0];
                    CFG_COUNT: count = i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                o_checked++;
                if (answers_q.size() == 0) begin
                    o_err_count++;
                    $display("%0t: unexpected result value=%0d status=%0d sat=%0d",
                             $time, i_result_value, i_status, i_saturated);
                end else begin
                    want = answers_q.pop_front();
                    if (i_result_value !== want.value || i_status !== want.status ||
                        i_saturated !== want.sat) begin
                        o_err_count++;
                        $display({"%0t: mismatch expected value=%0d status=%0d sat=%0d,",
                                  " got value=%0d status=%0d sat=%0d"},
                                 $time, want.value, want.status, want.sat,
                                 i_result_value, i_status, i_saturated);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                answers_q.push_back(lookup(i_mode, i_point_index, i_point_time,
                                           i_point_value, i_query_time));
        end
        o_pending = answers_q.size();
    end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top: clock, reset, stimulus for the interpolator and the final verdict.
module tb;
    import tsli_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic                     i_mode = 1'b0;
    logic [ADDR_W-1:0]        i_point_index = '0;
    logic signed [DATA_W-1:0] i_point_time = '0;
    logic signed [DATA_W-1:0] i_point_value = '0;
    logic signed [DATA_W-1:0] i_query_time = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b1;
    logic signed [DATA_W-1:0] o_result_value;
    logic [1:0]               o_status;
    logic                     o_saturated;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = CFG_SCALE;
    logic [DATA_W-1:0]        i_cfg_data = '0;

    int err_count;
    int pending;
    int checked;

    // Stimulus bookkeeping: idle profile, table shadow and counters.
    int                       send_idle_pct  = 0;
    int                       recv_stall_pct = 0;
    int                       items_sent     = 0;
    int                       query_count    = 0;
    int                       phase_count    = 0;
    logic signed [DATA_W-1:0] table_time [MAX_POINTS];

    time_series_linear_interpolator_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_point_index (i_point_index),
        .i_point_time  (i_point_time),
        .i_point_value (i_point_value),
        .i_query_time  (i_query_time),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_value(o_result_value),
        .o_status      (o_status),
        .o_saturated   (o_saturated),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    tsli_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_point_index (i_point_index),
        .i_point_time  (i_point_time),
        .i_point_value (i_point_value),
        .i_query_time  (i_query_time),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_result_value(o_result_value),
        .i_status      (o_status),
        .i_saturated   (o_saturated),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_err_count   (err_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver back-pressure: redraw ready on every falling edge.
    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard limit on the run, far beyond the slowest legal schedule.
    initial begin
        #30_000_000;
        $display("FAIL time_series_linear_interpolator_top");
        $finish;
    end

    // Present one transaction, with optional idle cycles first; hold until taken.
    task automatic send(logic m, logic [ADDR_W-1:0] idx, logic signed [DATA_W-1:0] pt,
                        logic signed [DATA_W-1:0] pv, logic signed [DATA_W-1:0] qt);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_mode        = m;
        i_point_index = idx;
        i_point_time  = pt;
        i_point_value = pv;
        i_query_time  = qt;
        i_in_valid    = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic load_point(int idx, logic signed [DATA_W-1:0] pt,
                              logic signed [DATA_W-1:0] pv);
        table_time[idx] = pt;
        send(1'b0, idx[ADDR_W-1:0], pt, pv, $urandom);
    endtask

    task automatic ask(logic signed [DATA_W-1:0] qt);
        query_count++;
        send(1'b1, ADDR_W'($urandom), $urandom, $urandom, qt);
    endtask

    // Drop valid and wait until every predicted result has come back, then let it settle.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (pending == 0);
        repeat (80) @(negedge i_clk);
    endtask

    // Register write; only issued after drain, so the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Fill entries 0..n-1 with rising times and mixed values.
    task automatic fill_table(int n);
        logic signed [DATA_W-1:0] t;
        logic signed [DATA_W-1:0] v;
        t = ($urandom_range(3) == 0) ? 32'sd0 : $urandom_range(0, 1 << 16);
        for (int i = 0; i < n; i++) begin
            v = ($urandom_range(2) == 0) ? $signed($urandom_range(0, 1 << 20)) - 32'sd524288
                                         : $signed($urandom);
            load_point(i, t, v);
            t = t + $urandom_range(1, 1 << 18);
        end
    endtask

    // Query time: mostly within the table, some on points, some negative or wild.
    function automatic logic signed [DATA_W-1:0] pick_time(int n, longint stp);
        int     r;
        longint hi;
        r = $urandom_range(99);
        if (r < 8) return $urandom | 32'h8000_0000;
        if (r < 14) return $urandom;
        if (stp == 0) begin
            if (r < 34) return table_time[$urandom_range(0, n - 1)];
            return $urandom_range(0, table_time[n-1] + 32'sd200000);
        end
        if (r < 24) return 32'(longint'($urandom_range(0, n)) * stp);
        hi = longint'(n + 1) * stp;
        if (hi > 64'sd2147483647) hi = 64'sd2147483647;
        return $urandom_range(0, 32'(hi));
    endfunction

    task automatic set_profile(int p);
        case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
        endcase
    endtask

    initial begin
        int          n;
        int          shown_n;
        longint      stp;
        logic [31:0] gain;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty table, then a four-point table with extreme values.
        ask(32'sd100);
        load_point(0, 32'sd0, 32'h7FFF_FFFF);
        load_point(1, 32'sd65536, 32'h8000_0000);
        load_point(2, 32'sd196608, 32'sd1000);
        load_point(3, 32'sd327680, -32'sd1000);
        drain();
        write_reg(CFG_COUNT, 32'd4);
        ask(-32'sd1);                  // negative time
        ask(32'sd0);                   // exactly on the cursor point
        ask(32'sd32768);               // between the first two points
        ask(32'sd262144);              // walk forward
        ask(32'sd393216);              // past the last point
        ask(32'sd65536);               // walk back, landing on a point
        ask(32'sd0);
        drain();
        write_reg(CFG_SCALE, 32'h7FFF_FFFF);
        ask(32'sd0);                   // clips high
        ask(32'sd32768);
        drain();
        write_reg(CFG_SCALE, 32'h8000_0000);
        ask(32'sd0);                   // clips low
        ask(32'sd65536);               // minimum times minimum clips high
        drain();
        write_reg(CFG_SCALE, 32'd65536);
        write_reg(CFG_STEP, 32'd65536);
        ask(32'sd32768);               // uniform spacing, interval zero
        ask(32'sd196608);              // last interval needs i+1 beyond the table
        ask(32'h7FFF_FFFF);
        drain();

        // Random phases: fresh table, new settings, then a burst of queries.
        while (items_sent < 600) begin
            set_profile(phase_count);
            phase_count++;
            case ($urandom_range(9))
                0:       n = 1;
                1:       n = 0;
                default: n = $urandom_range(2, 12);
            endcase
            if (n > 0) fill_table(n);
            drain();
            case ($urandom_range(5))
                0, 1, 2: stp = 0;
                3:       stp = 1;
                4:       stp = 32'h7FFF_FFFF;
                default: stp = $urandom_range(1, 1 << 20);
            endcase
            case ($urandom_range(5))
                0:       gain = 32'h7FFF_FFFF;
                1:       gain = 32'h8000_0000;
                2, 3:    gain = $urandom;
                default: gain = $urandom_range(0, 1 << 18) - (1 << 17);
            endcase
            write_reg(CFG_STEP, 32'(stp));
            write_reg(CFG_SCALE, gain);
            write_reg(CFG_COUNT, n);
            shown_n = (n == 0) ? 1 : n;
            repeat ($urandom_range(15, 40)) begin
                if ($urandom_range(11) == 0)
                    load_point($urandom_range(0, shown_n - 1), $urandom, $urandom);
                else
                    ask(pick_time(shown_n, stp));
            end
            drain();
        end

        // Full table, with the count register beyond the table size.
        set_profile(3);
        fill_table(MAX_POINTS);
        load_point(MAX_POINTS - 1, 32'h7FFF_FFFF, $urandom);
        drain();
        write_reg(CFG_STEP, 32'd0);
        write_reg(CFG_SCALE, 32'd65536);
        write_reg(CFG_COUNT, 32'd2047);
        set_profile(0);
        repeat (20) ask(pick_time(MAX_POINTS, 0));
        drain();
        write_reg(CFG_STEP, 32'd65536);
        set_profile(2);
        repeat (20) ask(pick_time(MAX_POINTS, 65536));
        drain();

        $display("Run covered %0d transactions (%0d queries) over %0d random phases.",
                 items_sent, query_count, phase_count);
        $display("Results checked: %0d, mismatches: %0d.", checked, err_count);
        if (err_count == 0) begin
            $display("PASS time_series_linear_interpolator_top");
        end else begin
            $display("FAIL time_series_linear_interpolator_top");
        end
        $finish;
    end

endmodule
